// ===== src/stid_pkg.sv =====
// ----------------------------------------------------------------------------
// stid_pkg: shared types for the sorted table
// Operation, status and cell command codes, and the control state encoding.
// ----------------------------------------------------------------------------
package stid_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

endpackage

// ===== src/stid_in_if.sv =====
// ----------------------------------------------------------------------------
// stid_in_if: request channel
// Carries one operation word: op code and operand value.
// ----------------------------------------------------------------------------
interface stid_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [stid_pkg::OP_W-1:0]     op;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

// ===== src/stid_out_if.sv =====
// ----------------------------------------------------------------------------
// stid_out_if: response channel
// Carries one result word: entry value, status, entry count and last flag.
// ----------------------------------------------------------------------------
interface stid_out_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] entry_value;
  logic [stid_pkg::STATUS_W-1:0] status;
  logic [stid_pkg::COUNT_W-1:0]  entry_count;
  logic                          last;

  modport source (output valid, output entry_value, output status, output entry_count,
                  output last, input ready);
  modport sink   (input valid, input entry_value, input status, input entry_count,
                  input last, output ready);
endinterface

// ===== src/stid_cell.sv =====
// ----------------------------------------------------------------------------
// stid_cell: one slot of the sorted table
// Holds one entry, compares it with the operand and takes its next value
// from itself, the operand, a neighbor or the head cell depending on the broadcast command.
// ----------------------------------------------------------------------------
module stid_cell #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned CNT_W       = 6,
  parameter int unsigned INDEX       = 0
) (
  input  logic                          clk_i,
  input  stid_pkg::cell_op_e            cmd_i,
  input  logic [CNT_W-1:0]              count_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic signed [VALUE_WIDTH-1:0] head_i,
  input  logic signed [VALUE_WIDTH-1:0] left_i,
  input  logic                          left_ge_i,
  input  logic signed [VALUE_WIDTH-1:0] right_i,
  output logic signed [VALUE_WIDTH-1:0] entry_o,
  output logic                          ge_o,
  output logic                          eq_o
);
  import stid_pkg::*;

  localparam logic [CNT_W-1:0] Idx     = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] IdxNext = CNT_W'(INDEX + 1);

  logic signed [VALUE_WIDTH-1:0] entry_q, entry_d;
  logic                          occ, tail;

  assign occ  = Idx < count_i;
  assign tail = count_i == IdxNext;
  assign ge_o = occ && (entry_q >= value_i);
  assign eq_o = occ && (entry_q == value_i);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i)
      CELL_INSERT: begin
        // entries at or above the insert point move up by one
        if (left_ge_i) begin
          entry_d = left_i;
        end else if (ge_o || !occ) begin
          entry_d = value_i;
        end
      end
      CELL_DELETE: begin
        if (ge_o) begin
          entry_d = right_i;
        end
      end
      CELL_ROTATE: begin
        entry_d = tail ? head_i : right_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== src/sorted_table_insert_delete.sv =====
// ----------------------------------------------------------------------------
// sorted_table_insert_delete: sorted table with insert, delete and dump
// Keeps up to CAPACITY signed values in ascending order in a row of cells.
//
// Request channel req_i carries op and value; response channel rsp_o carries
// entry_value, status, entry_count and last. Words move on valid && ready.
// Insert: all cells compare against the operand in parallel and shift up
// behind the insert point together; one response word.
// Delete: cells at or above the first match shift down together; one
// response word, status not found when no cell matches.
// Dump: the cell row rotates once per response word, cell 0 feeding the
// output, so N entries give N words and leave the row in its original order.
// Each request is registered before it executes, and every response word
// leaves through the response register.
// Requests are taken only between items; the response register decouples the
// sides, so a request is taken while the last response still waits.
// A stalled receiver freezes the cell row and the dump position.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_table_insert_delete #(
  parameter int unsigned CAPACITY    = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stid_in_if.sink    req_i,
  stid_out_if.source rsp_o
);
  import stid_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] Full = CntW'(CAPACITY);

  state_e                        state_q, state_d;
  op_e                           op_q;
  logic signed [VALUE_WIDTH-1:0] val_q;
  logic [CntW-1:0]               count_q, count_d;
  logic [CntW-1:0]               dump_idx_q, dump_idx_d;

  logic                          out_valid_q, out_valid_d;
  logic signed [VALUE_WIDTH-1:0] out_value_q, out_value_d;
  status_e                       out_status_q, out_status_d;
  logic [COUNT_W-1:0]            out_count_q, out_count_d;
  logic                          out_last_q, out_last_d;

  cell_op_e                      cell_cmd;
  logic signed [VALUE_WIDTH-1:0] entry   [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] left_v  [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] right_v [CAPACITY];
  logic [CAPACITY-1:0]           ge, eq, left_ge;

  logic slot_free, full, found, dump_tail, accept;

  // Cell row
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      left_v[i]  = (i == 0) ? '0 : entry[(i == 0) ? 0 : i - 1];
      left_ge[i] = (i == 0) ? 1'b0 : ge[(i == 0) ? 0 : i - 1];
      right_v[i] = (i == CAPACITY - 1) ? '0 : entry[(i == CAPACITY - 1) ? i : i + 1];
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    stid_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CNT_W       (CntW),
      .INDEX       (g)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cell_cmd),
      .count_i   (count_q),
      .value_i   (val_q),
      .head_i    (entry[0]),
      .left_i    (left_v[g]),
      .left_ge_i (left_ge[g]),
      .right_i   (right_v[g]),
      .entry_o   (entry[g]),
      .ge_o      (ge[g]),
      .eq_o      (eq[g])
    );
  end

  assign full      = count_q == Full;
  assign found     = |eq;
  assign dump_tail = CntW'(dump_idx_q + 1'b1) == count_q;
  assign slot_free = !out_valid_q || rsp_o.ready;
  assign accept    = req_i.valid && req_i.ready;

  assign req_i.ready       = state_q == S_IDLE;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.entry_value = out_value_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.entry_count = out_count_q;
  assign rsp_o.last        = out_last_q;

  // Control
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    dump_idx_d   = dump_idx_q;
    cell_cmd     = CELL_HOLD;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d    = S_EXEC;
          dump_idx_d = '0;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = '0;
          out_status_d = ST_OK;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
          unique case (op_q)
            OP_INSERT: begin
              if (full) begin
                out_status_d = ST_FULL;
              end else begin
                cell_cmd = CELL_INSERT;
                count_d  = CntW'(count_q + 1'b1);
              end
            end
            OP_DELETE: begin
              if (found) begin
                cell_cmd = CELL_DELETE;
                count_d  = CntW'(count_q - 1'b1);
              end else begin
                out_status_d = ST_NOT_FOUND;
              end
            end
            OP_DUMP: begin
              if (count_q == '0) begin
                out_status_d = ST_EMPTY;
              end else begin
                cell_cmd    = CELL_ROTATE;
                out_value_d = entry[0];
                out_last_d  = dump_tail;
                dump_idx_d  = CntW'(dump_idx_q + 1'b1);
                if (!dump_tail) begin
                  state_d = S_EXEC;
                end
              end
            end
            default: begin
              out_status_d = ST_OK;
            end
          endcase
          out_count_d = COUNT_W'(count_d);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      dump_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dump_idx_q  <= dump_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(req_i.op);
      val_q <= req_i.value;
    end
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && op_q == OP_INSERT && !full && slot_free)
    |=> count_q == CntW'($past(count_q) + 1'b1))
    else $error("insert did not grow the table");

  a_dump_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && op_q == OP_DUMP && count_q != '0) |-> dump_idx_q < count_q)
    else $error("dump position past the last entry");

  a_dump_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && op_q == OP_DUMP) |=> $stable(count_q))
    else $error("dump changed the entry count");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for sorted_table_insert_delete
// Drives insert, delete, dump and no-op requests through the request channel
// and keeps a sorted copy of the table to predict every response word.
// Responses are checked field by field, in order, as they leave the block.
// A directed pass covers value extremes, duplicates and an empty table; a fill
// pass overfills and drains the table. Random phases follow, with and without
// sender gaps and receiver stalls. A long receiver hold-off makes the block back
// up and stall its input.
module tb_top;
  import stid_pkg::*;

  localparam int unsigned CAPACITY    = 32;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int          DRAIN_WAIT  = 10;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          HOLD_CYCLES = 300;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    value_t             value;
    status_e            status;
    logic [COUNT_W-1:0] count;
    logic               last;
  } rsp_word_t;

  logic clk;
  logic rst_n;

  stid_in_if  #(.VALUE_WIDTH(VALUE_WIDTH)) req_if ();
  stid_out_if #(.VALUE_WIDTH(VALUE_WIDTH)) rsp_if ();

  sorted_table_insert_delete #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  value_t    sorted_q[$];
  rsp_word_t rsp_word_q[$];

  int   err_cnt        = 0;
  int   req_cnt        = 0;
  int   rsp_cnt        = 0;
  int   full_drop_cnt  = 0;
  int   peak_fill      = 0;
  int   cycle_cnt      = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic rx_hold        = 1'b0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d words still expected",
             cycle_cnt, rsp_word_q.size());
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("[%0t] ERROR: %s", $time, what);
  endtask

  // sorted table predictor
  task automatic push_rsp(input value_t val, input status_e st, input logic lst);
    rsp_word_t w;
    w.value  = val;
    w.status = st;
    w.count  = COUNT_W'(sorted_q.size());
    w.last   = lst;
    rsp_word_q.push_back(w);
  endtask

  task automatic predict_table_op(input op_e op, input value_t val);
    int pos;
    pos = 0;
    case (op)
      OP_INSERT: begin
        if (sorted_q.size() >= CAPACITY) begin
          full_drop_cnt++;
          push_rsp('0, ST_FULL, 1'b1);
        end else begin
          while (pos < sorted_q.size() && sorted_q[pos] < val) pos++;
          sorted_q.insert(pos, val);
          if (sorted_q.size() > peak_fill) peak_fill = sorted_q.size();
          push_rsp('0, ST_OK, 1'b1);
        end
      end
      OP_DELETE: begin
        while (pos < sorted_q.size() && sorted_q[pos] != val) pos++;
        if (pos >= sorted_q.size()) begin
          push_rsp('0, ST_NOT_FOUND, 1'b1);
        end else begin
          sorted_q.delete(pos);
          push_rsp('0, ST_OK, 1'b1);
        end
      end
      OP_DUMP: begin
        if (sorted_q.size() == 0) begin
          push_rsp('0, ST_EMPTY, 1'b1);
        end else begin
          foreach (sorted_q[i]) push_rsp(sorted_q[i], ST_OK, i == sorted_q.size() - 1);
        end
      end
      default: begin
        push_rsp('0, ST_OK, 1'b1);
      end
    endcase
  endtask

  // one request word; valid stays high after acceptance until the next call
  task automatic send_word(input op_e op, input value_t val);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.value <= val;
    do @(posedge clk); while (!req_if.ready);
    req_cnt++;
    predict_table_op(op, val);
  endtask

  task automatic wait_drain();
    req_if.valid <= 1'b0;
    while (rsp_word_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic check_rsp();
    rsp_word_t want;
    if (rsp_word_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word value=%0d status=%0d count=%0d",
                                rsp_if.entry_value, rsp_if.status, rsp_if.entry_count));
      return;
    end
    want = rsp_word_q.pop_front();
    rsp_cnt++;
    if (rsp_if.entry_value !== want.value)
      report_mismatch($sformatf("entry_value %0d, expected %0d",
                                rsp_if.entry_value, want.value));
    if (rsp_if.status !== want.status)
      report_mismatch($sformatf("status %0d, expected %s", rsp_if.status, want.status.name()));
    if (rsp_if.entry_count !== want.count)
      report_mismatch($sformatf("entry_count %0d, expected %0d",
                                rsp_if.entry_count, want.count));
    if (rsp_if.last !== want.last)
      report_mismatch($sformatf("last %b, expected %b", rsp_if.last, want.last));
  endtask

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) check_rsp();
      if (rx_hold) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic value_t pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 50) return value_t'($signed($urandom_range(16)) - 8);
    if (r < 90) return value_t'($urandom);
    case ($urandom_range(3))
      0: return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      1: return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic value_t pick_stored();
    if (sorted_q.size() == 0) return pick_value();
    return sorted_q[$urandom_range(sorted_q.size() - 1)];
  endfunction

  task automatic send_random_word();
    int r;
    int ins_pct;
    r = $urandom_range(99);
    ins_pct = (sorted_q.size() >= 30) ? 30 : (sorted_q.size() >= 24) ? 42 : 50;
    if (r < ins_pct) begin
      send_word(OP_INSERT, pick_value());
    end else if (r < 88) begin
      if ($urandom_range(99) < 70) send_word(OP_DELETE, pick_stored());
      else send_word(OP_DELETE, pick_value());
    end else if (r < 96) begin
      send_word(OP_DUMP, value_t'($urandom));
    end else begin
      send_word(OP_NOP, value_t'($urandom));
    end
  endtask

  task automatic test_directed();
    value_t vmin;
    value_t vmax;
    vmin = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    vmax = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(OP_DUMP, '0);
    send_word(OP_DELETE, 5);
    send_word(OP_NOP, '1);
    send_word(OP_INSERT, 0);
    send_word(OP_INSERT, vmax);
    send_word(OP_INSERT, vmin);
    send_word(OP_INSERT, -1);
    send_word(OP_INSERT, 1);
    send_word(OP_INSERT, 1);
    send_word(OP_INSERT, vmax);
    send_word(OP_DUMP, vmax);
    send_word(OP_DELETE, 1);
    send_word(OP_DELETE, 2);
    send_word(OP_DELETE, vmin);
    send_word(OP_DELETE, vmax);
    send_word(OP_NOP, vmin);
    send_word(OP_DUMP, '0);
    send_word(OP_DELETE, -1);
    send_word(OP_DELETE, 0);
    send_word(OP_DELETE, 1);
    send_word(OP_DELETE, vmax);
    send_word(OP_DUMP, '0);
    send_word(OP_DELETE, vmax);
    wait_drain();
  endtask

  task automatic test_fill_and_drain();
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    while (sorted_q.size() < CAPACITY) send_word(OP_INSERT, pick_value());
    repeat (3) send_word(OP_INSERT, pick_value());
    send_word(OP_DUMP, '0);
    send_word(OP_NOP, '0);
    while (sorted_q.size() > 0) begin
      send_word(OP_DELETE, pick_stored());
      if (sorted_q.size() == CAPACITY / 2) send_word(OP_DUMP, '0);
    end
    send_word(OP_DUMP, '0);
    wait_drain();
  endtask

  task automatic test_random(input int n_words, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_words) send_random_word();
    wait_drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (40) send_random_word();
    wait_drain();
  endtask

  initial begin
    rst_n        = 1'b0;
    req_if.valid = 1'b0;
    req_if.op    = OP_NOP;
    req_if.value = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_drain();
    test_random(60, 0, 0);
    test_random(60, 68, 0);
    test_random(60, 0, 68);
    test_random(60, 25, 25);
    test_backpressure();

    $display("%0d requests sent, %0d response words checked, %0d mismatches",
             req_cnt, rsp_cnt, err_cnt);
    $display("peak fill %0d of %0d, %0d inserts dropped on a full table",
             peak_fill, CAPACITY, full_drop_cnt);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/stid_pkg.sv
src/stid_in_if.sv
src/stid_out_if.sv
src/stid_cell.sv
src/sorted_table_insert_delete.sv
tb/sv/tb_top.sv
